>>> rtl/delta_list_callout_timer_defines.svh
// assertion macros for the delta list callout timer
`ifndef DELTA_LIST_CALLOUT_TIMER_DEFINES_SVH
`define DELTA_LIST_CALLOUT_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
`define DLCT_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define DLCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DLCT_ASSERT(label, prop)
`define DLCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/dlct_pkg.sv
// shared types and constants of the delta list callout timer
package dlct_pkg;

    localparam int MAX_FIRE = 16;

    localparam logic [1:0] RK_NONE   = 2'd0;
    localparam logic [1:0] RK_FIRED  = 2'd1;
    localparam logic [1:0] RK_INS_OK = 2'd2;
    localparam logic [1:0] RK_FULL   = 2'd3;

    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic        high_priority;
        logic [15:0] handler;
        logic [31:0] argument;
        logic [15:0] delay;
    } t_req;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] fired_handler;
        logic [31:0] fired_argument;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [15:0] delta;
        logic [15:0] handler;
        logic [31:0] argument;
    } t_entry;

endpackage

>>> rtl/dlct_ram.sv
// single port pair entry memory with registered read data
module dlct_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [ADDR_W-1:0]     i_waddr,
    input  dlct_pkg::t_entry      i_wdata,
    input  logic [ADDR_W-1:0]     i_raddr,
    output dlct_pkg::t_entry      o_rdata
);

    dlct_pkg::t_entry r_mem [DEPTH];
    dlct_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/delta_list_callout_timer.sv
// delta list callout timer: request sequencer around the entry memory
//
// Requests are taken when i_start is high and o_busy is low. Every request
// gives one or more results, each shown for a single cycle with o_valid; the
// receiver cannot stall, and the final result of a request has last set. An
// insert visits stored entries one at a time through the memory read port,
// each with a read state and a check state since read data is registered; a
// full list is rejected without visiting entries. A tick passes leading
// zero-delta entries, decrements the first non-zero one and, unless
// high_priority is set, fires the leading zero-delta entries and compacts the
// list. Results of firing come out one per fired entry, at most 16 per tick;
// a tick that fires nothing gives a single RK_NONE result.
`include "delta_list_callout_timer_defines.svh"

module delta_list_callout_timer #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  dlct_pkg::t_req  i_req,
    output logic            o_busy,
    output logic            o_valid,
    output dlct_pkg::t_rsp  o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INS_RD   = 12'b0000_0000_0010,
        S_INS_CHK  = 12'b0000_0000_0100,
        S_SH_RD    = 12'b0000_0000_1000,
        S_SH_WR    = 12'b0000_0001_0000,
        S_DEC_RD   = 12'b0000_0010_0000,
        S_DEC_CHK  = 12'b0000_0100_0000,
        S_FIRE_RD  = 12'b0000_1000_0000,
        S_FIRE_CHK = 12'b0001_0000_0000,
        S_FIRE_END = 12'b0010_0000_0000,
        S_CMP_RD   = 12'b0100_0000_0000,
        S_CMP_WR   = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_fired, n_fired;
    logic [15:0]       r_rem, n_rem;
    dlct_pkg::t_req    r_req, n_req;
    logic              r_pend_v, n_pend_v;
    logic [15:0]       r_pend_h, n_pend_h;
    logic [31:0]       r_pend_a, n_pend_a;
    logic              r_valid, n_valid;
    dlct_pkg::t_rsp    r_rsp, n_rsp;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    dlct_pkg::t_entry  mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    dlct_pkg::t_entry  mem_rdata;

    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  cmp_dst;
    logic              fire_stop;

    dlct_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_m1    = r_idx - CNT_W'(1);
    assign cmp_dst   = r_idx - r_fired;
    assign fire_stop = (r_fired == r_count) || (32'(r_fired) == dlct_pkg::MAX_FIRE);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_fired   = r_fired;
        n_rem     = r_rem;
        n_req     = r_req;
        n_pend_v  = r_pend_v;
        n_pend_h  = r_pend_h;
        n_pend_a  = r_pend_a;
        n_valid   = 1'b0;
        n_rsp     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_idx[IDX_W-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_idx    = '0;
                    n_rem    = i_req.delay;
                    n_pend_v = 1'b0;
                    if (i_req.kind == dlct_pkg::KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_valid           = 1'b1;
                            n_rsp.result_kind = dlct_pkg::RK_FULL;
                            n_rsp.last        = 1'b1;
                        end else begin
                            n_state = S_INS_RD;
                        end
                    end else begin
                        n_state = S_DEC_RD;
                    end
                end
            end
            S_INS_RD: begin
                if (r_idx == r_count) begin
                    n_pos   = r_idx;
                    n_state = S_SH_RD;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (mem_rdata.delta <= r_rem) begin
                    n_rem   = r_rem - mem_rdata.delta;
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_INS_RD;
                end else begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = S_SH_RD;
                end
            end
            S_SH_RD: begin
                mem_raddr = idx_m1[IDX_W-1:0];
                if (r_idx == r_pos) begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_pos[IDX_W-1:0];
                    mem_wdata.delta    = r_rem;
                    mem_wdata.handler  = r_req.handler;
                    mem_wdata.argument = r_req.argument;
                    n_count            = r_count + CNT_W'(1);
                    n_valid            = 1'b1;
                    n_rsp.result_kind  = dlct_pkg::RK_INS_OK;
                    n_rsp.last         = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
                mem_wdata = mem_rdata;
                if (idx_m1 == r_pos) begin
                    mem_wdata.delta = mem_rdata.delta - r_rem;
                end
                n_idx   = idx_m1;
                n_state = S_SH_RD;
            end
            S_DEC_RD: begin
                n_fired = '0;
                if (r_idx == r_count) begin
                    n_state = S_FIRE_END;
                    if (!r_req.high_priority) begin
                        n_state = S_FIRE_RD;
                    end
                end else begin
                    n_state = S_DEC_CHK;
                end
            end
            S_DEC_CHK: begin
                n_fired = '0;
                if (mem_rdata.delta != 16'd0) begin
                    mem_we          = 1'b1;
                    mem_wdata.delta = mem_rdata.delta - 16'd1;
                    n_state         = S_FIRE_END;
                    if (!r_req.high_priority) begin
                        n_state = S_FIRE_RD;
                    end
                end else begin
                    n_idx   = r_idx + CNT_W'(1);
                    n_state = S_DEC_RD;
                end
            end
            S_FIRE_RD: begin
                mem_raddr = r_fired[IDX_W-1:0];
                if (fire_stop) begin
                    n_state = S_FIRE_END;
                end else begin
                    n_state = S_FIRE_CHK;
                end
            end
            S_FIRE_CHK: begin
                if (mem_rdata.delta == 16'd0) begin
                    if (r_pend_v) begin
                        n_valid              = 1'b1;
                        n_rsp.result_kind    = dlct_pkg::RK_FIRED;
                        n_rsp.fired_handler  = r_pend_h;
                        n_rsp.fired_argument = r_pend_a;
                    end
                    n_pend_v = 1'b1;
                    n_pend_h = mem_rdata.handler;
                    n_pend_a = mem_rdata.argument;
                    n_fired  = r_fired + CNT_W'(1);
                    n_state  = S_FIRE_RD;
                end else begin
                    n_state = S_FIRE_END;
                end
            end
            S_FIRE_END: begin
                n_valid    = 1'b1;
                n_rsp.last = 1'b1;
                if (r_pend_v) begin
                    n_rsp.result_kind    = dlct_pkg::RK_FIRED;
                    n_rsp.fired_handler  = r_pend_h;
                    n_rsp.fired_argument = r_pend_a;
                end else begin
                    n_rsp.result_kind = dlct_pkg::RK_NONE;
                end
                n_pend_v = 1'b0;
                n_idx    = r_fired;
                if (r_fired == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                if (r_idx == r_count) begin
                    n_count = r_count - r_fired;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_CMP_WR;
                end
            end
            S_CMP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cmp_dst[IDX_W-1:0];
                mem_wdata = mem_rdata;
                n_idx     = r_idx + CNT_W'(1);
                n_state   = S_CMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pend_v <= n_pend_v;
            r_valid  <= n_valid;
        end
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_fired  <= n_fired;
        r_rem    <= n_rem;
        r_req    <= n_req;
        r_pend_h <= n_pend_h;
        r_pend_a <= n_pend_a;
        r_rsp    <= n_rsp;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `DLCT_ASSERT(a_count_in_range, r_count <= CNT_W'(CAPACITY))
    `DLCT_ASSERT_NEXT(a_busy_after_walk, i_start && !o_busy && (i_req.kind == dlct_pkg::KIND_TICK), o_busy)
    `DLCT_ASSERT(a_insert_counts, (o_valid && (o_rsp.result_kind == dlct_pkg::RK_INS_OK)) |-> (r_count == CNT_W'($past(r_count) + CNT_W'(1))))
    `DLCT_ASSERT(a_full_reject, (o_valid && (o_rsp.result_kind == dlct_pkg::RK_FULL)) |-> (r_count == CNT_W'(CAPACITY)))

endmodule

>>> verif/tb.sv
// self-checking testbench for the delta list callout timer
module tb;

    localparam int CAP          = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 4 * CAP + 16;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    dlct_pkg::t_req i_req   = '0;
    logic           o_busy;
    logic           o_valid;
    dlct_pkg::t_rsp o_rsp;

    dlct_pkg::t_entry pending [CAP];
    int               pending_count = 0;
    dlct_pkg::t_rsp   expected_rsp [$];
    int               mismatch_count = 0;
    int               cycle_count = 0;

    delta_list_callout_timer #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    function automatic void predict_callouts(input dlct_pkg::t_req r);
        int             pos;
        int             idx;
        int             nfire;
        logic [15:0]    remaining;
        logic           found;
        dlct_pkg::t_rsp rsp;
        if (r.kind == dlct_pkg::KIND_INSERT) begin
            rsp = '0;
            rsp.last = 1'b1;
            if (pending_count >= CAP) begin
                rsp.result_kind = dlct_pkg::RK_FULL;
            end else begin
                remaining = r.delay;
                pos = 0;
                while (pos < pending_count && pending[pos].delta <= remaining) begin
                    remaining = remaining - pending[pos].delta;
                    pos++;
                end
                if (pos < pending_count)
                    pending[pos].delta = pending[pos].delta - remaining;
                for (idx = pending_count; idx > pos; idx--)
                    pending[idx] = pending[idx - 1];
                pending[pos].delta    = remaining;
                pending[pos].handler  = r.handler;
                pending[pos].argument = r.argument;
                pending_count++;
                rsp.result_kind = dlct_pkg::RK_INS_OK;
            end
            expected_rsp.push_back(rsp);
        end else begin
            found = 1'b0;
            for (idx = 0; idx < pending_count; idx++) begin
                if (!found && pending[idx].delta != 16'd0) begin
                    pending[idx].delta = pending[idx].delta - 16'd1;
                    found = 1'b1;
                end
            end
            nfire = 0;
            if (!r.high_priority) begin
                while (nfire < pending_count && nfire < dlct_pkg::MAX_FIRE &&
                       pending[nfire].delta == 16'd0)
                    nfire++;
            end
            for (idx = 0; idx < nfire; idx++) begin
                rsp.result_kind    = dlct_pkg::RK_FIRED;
                rsp.fired_handler  = pending[idx].handler;
                rsp.fired_argument = pending[idx].argument;
                rsp.last           = (idx == nfire - 1);
                expected_rsp.push_back(rsp);
            end
            if (nfire > 0) begin
                for (idx = nfire; idx < pending_count; idx++)
                    pending[idx - nfire] = pending[idx];
                pending_count = pending_count - nfire;
            end else begin
                rsp = '0;
                rsp.result_kind = dlct_pkg::RK_NONE;
                rsp.last = 1'b1;
                expected_rsp.push_back(rsp);
            end
        end
    endfunction

    task automatic check_result(input dlct_pkg::t_rsp got);
        dlct_pkg::t_rsp exp_rsp;
        if (expected_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d", got.result_kind));
        end else begin
            exp_rsp = expected_rsp.pop_front();
            if (got.result_kind !== exp_rsp.result_kind)
                report_mismatch($sformatf("result_kind got %0d want %0d",
                                          got.result_kind, exp_rsp.result_kind));
            if (got.fired_handler !== exp_rsp.fired_handler)
                report_mismatch($sformatf("fired_handler got %h want %h",
                                          got.fired_handler, exp_rsp.fired_handler));
            if (got.fired_argument !== exp_rsp.fired_argument)
                report_mismatch($sformatf("fired_argument got %h want %h",
                                          got.fired_argument, exp_rsp.fired_argument));
            if (got.last !== exp_rsp.last)
                report_mismatch($sformatf("last got %b want %b", got.last, exp_rsp.last));
        end
    endtask

    // accepted requests are predicted before results of the same edge are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy)
                predict_callouts(i_req);
            if (o_valid)
                check_result(o_rsp);
        end
    end

    function automatic dlct_pkg::t_req make_insert(input logic [15:0] handler,
                                                   input logic [31:0] argument,
                                                   input logic [15:0] delay);
        dlct_pkg::t_req r;
        r.kind          = dlct_pkg::KIND_INSERT;
        r.high_priority = 1'($urandom_range(0, 1));
        r.handler       = handler;
        r.argument      = argument;
        r.delay         = delay;
        return r;
    endfunction

    function automatic dlct_pkg::t_req make_tick(input logic high);
        dlct_pkg::t_req r;
        r.kind          = dlct_pkg::KIND_TICK;
        r.high_priority = high;
        r.handler       = 16'($urandom);
        r.argument      = $urandom;
        r.delay         = 16'($urandom);
        return r;
    endfunction

    task automatic send_request(input dlct_pkg::t_req r);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
    endtask

    // stop starting requests and step the clock first so the request accepted last is already predicted
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_tick();
        send_request(make_tick(1'b0));
        send_request(make_tick(1'b1));
    endtask

    // full list of zero-delay entries: reject one more, then fire all at once
    task automatic test_burst_expiry();
        int idx;
        for (idx = 0; idx < CAP; idx++)
            send_request(make_insert(16'($urandom), $urandom, 16'd0));
        send_request(make_insert(16'($urandom), $urandom, 16'($urandom)));
        send_request(make_tick(1'b0));
    endtask

    task automatic test_ordering();
        send_request(make_insert(16'h0000, 32'h0000_0000, 16'd0));
        send_request(make_insert(16'hffff, 32'hffff_ffff, 16'd0));
        send_request(make_insert(16'($urandom), $urandom, 16'hffff));
        send_request(make_insert(16'($urandom), $urandom, 16'd3));
        send_request(make_insert(16'($urandom), $urandom, 16'd3));
        send_request(make_tick(1'b1));
        send_request(make_tick(1'b0));
    endtask

    task automatic test_random(input int count);
        int          idx;
        logic [15:0] delay;
        for (idx = 0; idx < count; idx++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 9) == 0)
                    delay = 16'($urandom);
                else
                    delay = 16'($urandom_range(0, 12));
                send_request(make_insert(16'($urandom), $urandom, delay));
            end else begin
                send_request(make_tick($urandom_range(0, 3) == 0));
            end
        end
    endtask

    initial begin
        int waited;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_tick();
        test_burst_expiry();
        test_ordering();
        drain_results();
        test_random(37);
        drain_results();
        test_random(37);

        i_start <= 1'b0;
        waited = 0;
        while (expected_rsp.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_rsp.size()));

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
